[src/ddo_pkg.sv]
// shared types, constants and the sequencer program for the odometry block
package ddo_pkg;

   // field widths
   localparam int SPEED_W     = 11;
   localparam int FWD_GAIN_W  = 24;
   localparam int TURN_GAIN_W = 26;
   localparam int RATE_W      = 16;
   localparam int VEL_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;

   // datapath widths
   localparam int DU_W     = 20;
   localparam int DIFF_W   = 22;
   localparam int MUL_A_W  = 22;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int CORDIC_W = 32;

   // fixed-point shifts
   localparam int FWD_SHIFT  = 17;
   localparam int TURN_SHIFT = 16;
   localparam int ROT_SHIFT  = 30;
   localparam int VEL_SHIFT  = 8;

   localparam logic signed [SPEED_W-1:0] MAX_WHEEL = 11'sd800;

   // register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] REG_FORWARD_GAIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_GAIN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RATE    = 2'd2;

   localparam logic [FWD_GAIN_W-1:0]  FWD_GAIN_RESET  = 24'd9059230;
   localparam logic [TURN_GAIN_W-1:0] TURN_GAIN_RESET = 26'd13863813;
   localparam logic [RATE_W-1:0]      STEP_RATE_RESET = 16'd4000;

   // sequencer
   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
   localparam logic [PC_W-1:0] STEP_FWD    = 4'd1;
   localparam logic [PC_W-1:0] STEP_TURN   = 4'd2;
   localparam logic [PC_W-1:0] STEP_HEAD   = 4'd3;
   localparam logic [PC_W-1:0] STEP_ROTATE = 4'd4;
   localparam logic [PC_W-1:0] STEP_SIN    = 4'd5;
   localparam logic [PC_W-1:0] STEP_COS    = 4'd6;
   localparam logic [PC_W-1:0] STEP_POSZ   = 4'd7;
   localparam logic [PC_W-1:0] STEP_VX     = 4'd8;
   localparam logic [PC_W-1:0] STEP_VZ     = 4'd9;
   localparam logic [PC_W-1:0] STEP_DONE   = 4'd10;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_NO_ITEM,
      COND_CORDIC,
      COND_STALL
   } cond_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FWD,
      MUL_TURN,
      MUL_SIN,
      MUL_COS,
      MUL_VX,
      MUL_VZ
   } mul_sel_type;

   typedef struct packed {
      cond_type          cond;
      logic [PC_W-1:0]   target;
      mul_sel_type       mul_sel;
      logic              capture;
      logic              cordic_iter;
      logic              load_du;
      logic              upd_heading;
      logic              upd_x;
      logic              upd_z;
      logic              load_vx;
      logic              load_vz;
      logic              load_out;
   } ctl_word_type;

   typedef struct packed {
      logic init;
      logic iter;
   } cordic_ctl_type;

   // control store: when cond holds jump to target, otherwise fall through
   function automatic ctl_word_type micro_rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      w = '0;
      case (pc)
         STEP_WAIT: begin
            w.cond    = COND_NO_ITEM;
            w.target  = STEP_WAIT;
            w.capture = 1'b1;
         end
         STEP_FWD: begin
            w.mul_sel     = MUL_FWD;
            w.cordic_iter = 1'b1;
         end
         STEP_TURN: begin
            w.mul_sel     = MUL_TURN;
            w.load_du     = 1'b1;
            w.cordic_iter = 1'b1;
         end
         STEP_HEAD: begin
            w.upd_heading = 1'b1;
            w.cordic_iter = 1'b1;
         end
         STEP_ROTATE: begin
            w.cond        = COND_CORDIC;
            w.target      = STEP_ROTATE;
            w.cordic_iter = 1'b1;
         end
         STEP_SIN: begin
            w.mul_sel = MUL_SIN;
         end
         STEP_COS: begin
            w.mul_sel = MUL_COS;
            w.upd_x   = 1'b1;
         end
         STEP_POSZ: begin
            w.mul_sel = MUL_VX;
            w.upd_z   = 1'b1;
         end
         STEP_VX: begin
            w.mul_sel = MUL_VZ;
            w.load_vx = 1'b1;
         end
         STEP_VZ: begin
            w.load_vz = 1'b1;
         end
         STEP_DONE: begin
            w.cond     = COND_STALL;
            w.target   = STEP_DONE;
            w.load_out = 1'b1;
         end
         default: begin
            w.cond   = COND_NONE;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

[src/ddo_cordic.sv]
// iterative cordic rotator giving cosine and sine of a binary angle
module ddo_cordic #(
   parameter int ANGLE_BITS = 24
) (
   input  logic                                   clock,
   input  ddo_pkg::cordic_ctl_type                ctl,
   input  logic [ANGLE_BITS-1:0]                  angle,
   output logic signed [ddo_pkg::CORDIC_W-1:0]    cos_out,
   output logic signed [ddo_pkg::CORDIC_W-1:0]    sin_out,
   output logic                                   last
);
   import ddo_pkg::*;

   localparam int CORDIC_STEPS = 24;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam logic signed [CORDIC_W-1:0] GAIN_INV = 32'sd652032874;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

   function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [ITER_W-1:0] i);
      logic signed [CORDIC_W-1:0] a;
      case (i)
         5'd0:    a = 32'sd536870912;
         5'd1:    a = 32'sd316933406;
         5'd2:    a = 32'sd167458907;
         5'd3:    a = 32'sd85004756;
         5'd4:    a = 32'sd42667331;
         5'd5:    a = 32'sd21354465;
         5'd6:    a = 32'sd10679838;
         5'd7:    a = 32'sd5340245;
         5'd8:    a = 32'sd2670163;
         5'd9:    a = 32'sd1335087;
         5'd10:   a = 32'sd667544;
         5'd11:   a = 32'sd333772;
         5'd12:   a = 32'sd166886;
         5'd13:   a = 32'sd83443;
         5'd14:   a = 32'sd41721;
         5'd15:   a = 32'sd20861;
         5'd16:   a = 32'sd10430;
         5'd17:   a = 32'sd5215;
         5'd18:   a = 32'sd2608;
         5'd19:   a = 32'sd1304;
         5'd20:   a = 32'sd652;
         5'd21:   a = 32'sd326;
         5'd22:   a = 32'sd163;
         5'd23:   a = 32'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic                       flip_ff, flip_in;

   logic [CORDIC_W-1:0]        angle_full;
   logic                       flip_now;
   logic signed [CORDIC_W-1:0] xs, ys, rot;

   always_comb begin
      angle_full = CORDIC_W'(angle) << (CORDIC_W - ANGLE_BITS);
      // second and third quadrant: turn by half a circle and negate at the end
      flip_now   = angle_full[CORDIC_W-1] ^ angle_full[CORDIC_W-2];
      xs         = x_ff >>> iter_ff;
      ys         = y_ff >>> iter_ff;
      rot        = atan_angle(iter_ff);

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      flip_in = flip_ff;

      if (ctl.init) begin
         x_in    = GAIN_INV;
         y_in    = '0;
         z_in    = angle_full ^ {flip_now, {(CORDIC_W-1){1'b0}}};
         iter_in = '0;
         flip_in = flip_now;
      end else if (ctl.iter) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - rot;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + rot;
         end
         iter_in = iter_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
   end

   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign last    = (iter_ff == LAST_ITER);

endmodule

[src/differential_drive_odometry.sv]
// differential-drive odometry: microcoded sequencer around one multiplier and a cordic
//
// Usage: each req item carries one control step's left and right wheel speed
// commands; speeds beyond +-800 are clamped. The block advances x, z and the
// heading and returns one rsp item with the new position, heading and the
// velocity of this step. Gains and step rate sit behind the csr write port,
// which is always ready; write only while no item is in flight.
// The sequencer takes the next item only after the result of the last one
// is loaded into the output register. Each item runs 24 cordic iterations,
// three of which overlap the gain multiplies and the heading update,
// followed by six steps that share the single multiplier and the
// saturating adder.
// A finished result sits in the output register until taken. A new item may
// be accepted while it waits; the sequencer holds in its last step if the
// previous result has still not been taken.
// Reset (synchronous) clears position and heading, loads the register reset
// values and empties the output register.
module differential_drive_odometry #(
   parameter int ANGLE_BITS    = 24,
   parameter int POSITION_BITS = 40
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [ddo_pkg::SPEED_W-1:0]     req_left_speed,
   input  logic signed [ddo_pkg::SPEED_W-1:0]     req_right_speed,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [POSITION_BITS-1:0]        rsp_pos_x,
   output logic signed [POSITION_BITS-1:0]        rsp_pos_z,
   output logic [ANGLE_BITS-1:0]                  rsp_heading,
   output logic signed [ddo_pkg::VEL_W-1:0]       rsp_vel_x,
   output logic signed [ddo_pkg::VEL_W-1:0]       rsp_vel_z,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ddo_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]         csr_data
);
   import ddo_pkg::*;

   localparam int SUM_W = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
   localparam logic [POSITION_BITS-1:0] POS_MAX = ~POS_MIN;
   localparam logic [VEL_W-1:0]         VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam logic [VEL_W-1:0]         VEL_MAX = ~VEL_MIN;

   function automatic logic signed [SPEED_W-1:0] clamp_wheel(
      input logic signed [SPEED_W-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > MAX_WHEEL)
         r = MAX_WHEEL;
      else if (v < -MAX_WHEEL)
         r = -MAX_WHEEL;
      else
         r = v;
      return r;
   endfunction

   // add half an lsb, then floor
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v, input int unsigned s);
      logic signed [PROD_W-1:0] half;
      half = PROD_W'(1) << (s - 1);
      return (v + half) >>> s;
   endfunction

   // control registers
   logic [PC_W-1:0]        pc_ff, pc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FWD_GAIN_W-1:0]  fwd_gain_ff, fwd_gain_in;
   logic [TURN_GAIN_W-1:0] turn_gain_ff, turn_gain_in;
   logic [RATE_W-1:0]      step_rate_ff, step_rate_in;
   logic signed [POSITION_BITS-1:0] x_ff, x_in, z_ff, z_in;
   logic [ANGLE_BITS-1:0]  heading_ff, heading_in;

   // datapath registers
   logic signed [SPEED_W-1:0]       left_ff, left_in, right_ff, right_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [DU_W-1:0]          du_ff, du_in;
   logic signed [DIFF_W-1:0]        dx_ff, dx_in, dz_ff, dz_in;
   logic signed [VEL_W-1:0]         vx_ff, vx_in, vz_ff, vz_in;
   logic signed [POSITION_BITS-1:0] out_x_ff, out_x_in, out_z_ff, out_z_in;
   logic [ANGLE_BITS-1:0]           out_head_ff, out_head_in;
   logic signed [VEL_W-1:0]         out_vx_ff, out_vx_in, out_vz_ff, out_vz_in;

   ctl_word_type   ctl;
   cordic_ctl_type cordic_ctl;
   logic           cond_hit, advance, cordic_last;
   logic signed [CORDIC_W-1:0] cos_val, sin_val;

   logic signed [SPEED_W:0]         wheel_sum, wheel_diff;
   logic signed [DU_W-1:0]          neg_du;
   logic signed [MUL_A_W-1:0]       mul_a;
   logic signed [MUL_B_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]        du_full, dth_full, rot_step, vel_full;
   logic signed [POSITION_BITS-1:0] pos_old, pos_new;
   logic signed [SUM_W-1:0]         pos_sum, pos_delta;
   logic signed [DIFF_W-1:0]        pos_change;
   logic [PROD_W-VEL_W:0]           vel_hi;
   logic signed [VEL_W-1:0]         vel_sat;

   // sequencer
   assign ctl = micro_rom(pc_ff);

   always_comb begin
      case (ctl.cond)
         COND_NONE:    cond_hit = 1'b0;
         COND_NO_ITEM: cond_hit = !req_valid;
         COND_CORDIC:  cond_hit = !cordic_last;
         COND_STALL:   cond_hit = rsp_valid_ff && !rsp_ready;
         default:      cond_hit = 1'b0;
      endcase
   end

   assign advance = !cond_hit;

   always_comb begin
      if (cond_hit)
         pc_in = ctl.target;
      else if (pc_ff == STEP_DONE)
         pc_in = STEP_WAIT;
      else
         pc_in = pc_ff + 1'b1;
   end

   assign req_ready = ctl.capture;
   assign csr_ready = 1'b1;

   assign cordic_ctl.init = ctl.capture && advance;
   assign cordic_ctl.iter = ctl.cordic_iter;

   ddo_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock   (clock),
      .ctl     (cordic_ctl),
      .angle   (heading_ff),
      .cos_out (cos_val),
      .sin_out (sin_val),
      .last    (cordic_last)
   );

   // shared multiplier
   always_comb begin
      wheel_sum  = {left_ff[SPEED_W-1], left_ff} + {right_ff[SPEED_W-1], right_ff};
      wheel_diff = {right_ff[SPEED_W-1], right_ff} - {left_ff[SPEED_W-1], left_ff};
      neg_du     = -du_ff;
      case (ctl.mul_sel)
         MUL_FWD: begin
            mul_a = MUL_A_W'(wheel_sum);
            mul_b = {{(MUL_B_W-FWD_GAIN_W){1'b0}}, fwd_gain_ff};
         end
         MUL_TURN: begin
            mul_a = MUL_A_W'(wheel_diff);
            mul_b = {{(MUL_B_W-TURN_GAIN_W){1'b0}}, turn_gain_ff};
         end
         MUL_SIN: begin
            mul_a = MUL_A_W'(neg_du);
            mul_b = sin_val;
         end
         MUL_COS: begin
            mul_a = MUL_A_W'(neg_du);
            mul_b = cos_val;
         end
         MUL_VX: begin
            mul_a = dx_ff;
            mul_b = {{(MUL_B_W-RATE_W){1'b0}}, step_rate_ff};
         end
         MUL_VZ: begin
            mul_a = dz_ff;
            mul_b = {{(MUL_B_W-RATE_W){1'b0}}, step_rate_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // rounding, saturating position adder and velocity clamp
   always_comb begin
      du_full  = round_shift(prod_ff, FWD_SHIFT);
      dth_full = round_shift(prod_ff, TURN_SHIFT);
      rot_step = round_shift(prod_ff, ROT_SHIFT);
      vel_full = round_shift(prod_ff, VEL_SHIFT);

      pos_old = ctl.upd_z ? z_ff : x_ff;
      pos_sum = SUM_W'(pos_old) + SUM_W'(rot_step);
      if (pos_sum[SUM_W-1] != pos_sum[SUM_W-2])
         pos_new = pos_sum[SUM_W-1] ? POS_MIN : POS_MAX;
      else
         pos_new = pos_sum[POSITION_BITS-1:0];
      pos_delta  = SUM_W'(pos_new) - SUM_W'(pos_old);
      pos_change = DIFF_W'(pos_delta);

      vel_hi = vel_full[PROD_W-1:VEL_W-1];
      if ((&vel_hi) || !(|vel_hi))
         vel_sat = vel_full[VEL_W-1:0];
      else
         vel_sat = vel_full[PROD_W-1] ? VEL_MIN : VEL_MAX;
   end

   // next state of control and odometry state
   always_comb begin
      fwd_gain_in  = fwd_gain_ff;
      turn_gain_in = turn_gain_ff;
      step_rate_in = step_rate_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FORWARD_GAIN: fwd_gain_in  = csr_data[FWD_GAIN_W-1:0];
            REG_TURN_GAIN:    turn_gain_in = csr_data[TURN_GAIN_W-1:0];
            REG_STEP_RATE:    step_rate_in = csr_data[RATE_W-1:0];
            default:          fwd_gain_in  = fwd_gain_ff;
         endcase
      end

      x_in       = ctl.upd_x ? pos_new : x_ff;
      z_in       = ctl.upd_z ? pos_new : z_ff;
      heading_in = ctl.upd_heading ? heading_ff + dth_full[ANGLE_BITS-1:0] : heading_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;
      if (ctl.load_out && advance)
         rsp_valid_in = 1'b1;
   end

   // next state of the datapath
   always_comb begin
      left_in     = (ctl.capture && advance) ? clamp_wheel(req_left_speed) : left_ff;
      right_in    = (ctl.capture && advance) ? clamp_wheel(req_right_speed) : right_ff;
      du_in       = ctl.load_du ? DU_W'(du_full) : du_ff;
      dx_in       = ctl.upd_x ? pos_change : dx_ff;
      dz_in       = ctl.upd_z ? pos_change : dz_ff;
      vx_in       = ctl.load_vx ? vel_sat : vx_ff;
      vz_in       = ctl.load_vz ? vel_sat : vz_ff;

      out_x_in    = out_x_ff;
      out_z_in    = out_z_ff;
      out_head_in = out_head_ff;
      out_vx_in   = out_vx_ff;
      out_vz_in   = out_vz_ff;
      if (ctl.load_out && advance) begin
         out_x_in    = x_ff;
         out_z_in    = z_ff;
         out_head_in = heading_ff;
         out_vx_in   = vx_ff;
         out_vz_in   = vz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         fwd_gain_ff  <= FWD_GAIN_RESET;
         turn_gain_ff <= TURN_GAIN_RESET;
         step_rate_ff <= STEP_RATE_RESET;
         x_ff         <= '0;
         z_ff         <= '0;
         heading_ff   <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_gain_ff  <= fwd_gain_in;
         turn_gain_ff <= turn_gain_in;
         step_rate_ff <= step_rate_in;
         x_ff         <= x_in;
         z_ff         <= z_in;
         heading_ff   <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      prod_ff     <= prod_in;
      du_ff       <= du_in;
      dx_ff       <= dx_in;
      dz_ff       <= dz_in;
      vx_ff       <= vx_in;
      vz_ff       <= vz_in;
      out_x_ff    <= out_x_in;
      out_z_ff    <= out_z_in;
      out_head_ff <= out_head_in;
      out_vx_ff   <= out_vx_in;
      out_vz_ff   <= out_vz_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_z   = out_z_ff;
   assign rsp_heading = out_head_ff;
   assign rsp_vel_x   = out_vx_ff;
   assign rsp_vel_z   = out_vz_ff;

endmodule

[tb/tb_differential_drive_odometry.sv]
// self-checking testbench for the differential-drive odometry block
module tb_differential_drive_odometry;
   timeunit 1ns;
   timeprecision 1ps;

   import ddo_pkg::*;

   localparam int POS_W = 40;
   localparam int ANG_W = 24;
   localparam int CORDIC_ITERS = 24;
   localparam longint CORDIC_SCALE = 652032874;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int DIRECTED_N = 22;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_z;
      logic [ANG_W-1:0]        heading;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_z;
   } odo_pose_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left;
      logic signed [SPEED_W-1:0] right;
      logic                      fixed_want;
      odo_pose_type              want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SPEED_W-1:0] req_left_speed = '0;
   logic signed [SPEED_W-1:0] req_right_speed = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_z;
   logic [ANG_W-1:0]          rsp_heading;
   logic signed [VEL_W-1:0]   rsp_vel_x;
   logic signed [VEL_W-1:0]   rsp_vel_z;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // predictor state and register copies
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] z_pos;
   logic [ANG_W-1:0]        head;
   longint                  fwd_gain_q;
   longint                  turn_gain_q;
   longint                  rate_q;

   odo_pose_type expected_poses[$];
   int        mismatch_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_requests = 0;
   int        holds_taken = 0;
   int        hold_left = 0;

   longint atan_table [CORDIC_ITERS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41721, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   step_row_type directed_steps [DIRECTED_N] = '{
      '{11'sd0, 11'sd0, 1'b1, '{40'sd0, 40'sd0, 24'd0, 32'sd0, 32'sd0}},
      '{11'sd800, 11'sd800, 1'b0, '0},
      '{-11'sd800, -11'sd800, 1'b0, '0},
      '{11'sd800, -11'sd800, 1'b0, '0},
      '{-11'sd800, 11'sd800, 1'b0, '0},
      '{11'sd1023, 11'sd1023, 1'b0, '0},
      '{11'sh400, 11'sh400, 1'b0, '0},
      '{11'sd1023, 11'sh400, 1'b0, '0},
      '{11'sh400, 11'sd1023, 1'b0, '0},
      '{11'sd801, -11'sd801, 1'b0, '0},
      '{-11'sd801, 11'sd801, 1'b0, '0},
      '{11'sd1, 11'sd0, 1'b0, '0},
      '{11'sd0, 11'sd1, 1'b0, '0},
      '{-11'sd1, 11'sd0, 1'b0, '0},
      '{11'sd0, -11'sd1, 1'b0, '0},
      '{11'sd800, 11'sd0, 1'b0, '0},
      '{11'sd0, -11'sd800, 1'b0, '0},
      '{-11'sd800, 11'sd800, 1'b0, '0},
      '{-11'sd800, 11'sd800, 1'b0, '0},
      '{-11'sd800, 11'sd800, 1'b0, '0},
      '{11'sd800, 11'sd800, 1'b0, '0},
      '{11'sd0, 11'sd0, 1'b0, '0}
   };

   differential_drive_odometry u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_speed  (req_left_speed),
      .req_right_speed (req_right_speed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_heading     (rsp_heading),
      .rsp_vel_x       (rsp_vel_x),
      .rsp_vel_z       (rsp_vel_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_long(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // add half an lsb, then floor
   function automatic longint round_shift(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   // q2.30 cosine and sine; second and third quadrants are turned by half a turn first
   function automatic void cordic_sin_cos(input logic [ANG_W-1:0] ang,
                                          output longint cos_q, output longint sin_q);
      logic [31:0] a;
      logic [31:0] t;
      logic        flip;
      longint      x, y, z, xs, ys;
      a = 32'(ang) << (32 - ANG_W);
      t = a + 32'h4000_0000;
      flip = t[31];
      if (flip) a = a ^ 32'h8000_0000;
      z = longint'($signed(a));
      x = CORDIC_SCALE;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_table[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_table[i];
         end
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   function automatic odo_pose_type advance_odometry(input logic signed [SPEED_W-1:0] left_raw,
                                                     input logic signed [SPEED_W-1:0] right_raw);
      longint    l, r, du, dth, c, s, nx, nz, vx, vz, lim, vlim;
      odo_pose_type p;
      l = clamp_long(longint'(left_raw), -longint'(MAX_WHEEL), longint'(MAX_WHEEL));
      r = clamp_long(longint'(right_raw), -longint'(MAX_WHEEL), longint'(MAX_WHEEL));
      lim = longint'(1) <<< (POS_W - 1);
      vlim = longint'(1) <<< (VEL_W - 1);
      du = round_shift((l + r) * fwd_gain_q, FWD_SHIFT);
      dth = round_shift((r - l) * turn_gain_q, TURN_SHIFT);
      // rotation uses the heading from before this step
      cordic_sin_cos(head, c, s);
      nx = clamp_long(longint'(x_pos) + round_shift(-du * s, ROT_SHIFT), -lim, lim - 1);
      nz = clamp_long(longint'(z_pos) + round_shift(-du * c, ROT_SHIFT), -lim, lim - 1);
      vx = clamp_long(round_shift((nx - longint'(x_pos)) * rate_q, VEL_SHIFT), -vlim, vlim - 1);
      vz = clamp_long(round_shift((nz - longint'(z_pos)) * rate_q, VEL_SHIFT), -vlim, vlim - 1);
      x_pos = nx[POS_W-1:0];
      z_pos = nz[POS_W-1:0];
      head = head + dth[ANG_W-1:0];
      p.pos_x = x_pos;
      p.pos_z = z_pos;
      p.heading = head;
      p.vel_x = vx[VEL_W-1:0];
      p.vel_z = vz[VEL_W-1:0];
      return p;
   endfunction

   function automatic logic signed [SPEED_W-1:0] pick_speed();
      int v;
      if ($urandom_range(99) < 15) begin
         v = int'($urandom_range(2047));
      end else begin
         v = int'($urandom_range(1600)) - 800;
      end
      return v[SPEED_W-1:0];
   endfunction

   task automatic send_step(input logic signed [SPEED_W-1:0] l,
                            input logic signed [SPEED_W-1:0] r,
                            input logic fixed_want, input odo_pose_type want);
      odo_pose_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_speed <= l;
      req_right_speed <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = advance_odometry(l, r);
      expected_poses.push_back(fixed_want ? want : p);
   endtask

   task automatic run_random(input int count);
      int                        kind;
      logic signed [SPEED_W-1:0] l, r;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         l = pick_speed();
         // straight runs and spins on the spot mixed into free pairs
         if (kind < 10) r = l;
         else if (kind < 20) r = -l;
         else r = pick_speed();
         send_step(l, r, 1'b0, '0);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FORWARD_GAIN: fwd_gain_q = longint'(data[FWD_GAIN_W-1:0]);
         REG_TURN_GAIN:    turn_gain_q = longint'(data[TURN_GAIN_W-1:0]);
         REG_STEP_RATE:    rate_q = longint'(data[RATE_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] fwd,
                            input logic [CSR_DATA_W-1:0] turn,
                            input logic [CSR_DATA_W-1:0] rate);
      write_reg(REG_FORWARD_GAIN, fwd);
      write_reg(REG_TURN_GAIN, turn);
      write_reg(REG_STEP_RATE, rate);
      write_reg(REG_UNMAPPED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // receiver side: random stalls plus the occasional long hold-off
   always @(posedge clock) begin : drive_rsp_ready
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken = holds_taken + 1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      odo_pose_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_poses.size() == 0) begin
            $error("result item with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_poses.pop_front();
            if (rsp_pos_x !== want.pos_x) begin
               $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_pos_x);
               mismatch_count++;
            end
            if (rsp_pos_z !== want.pos_z) begin
               $error("pos_z: expected %0d, got %0d", want.pos_z, rsp_pos_z);
               mismatch_count++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
               mismatch_count++;
            end
            if (rsp_vel_x !== want.vel_x) begin
               $error("vel_x: expected %0d, got %0d", want.vel_x, rsp_vel_x);
               mismatch_count++;
            end
            if (rsp_vel_z !== want.vel_z) begin
               $error("vel_z: expected %0d, got %0d", want.vel_z, rsp_vel_z);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      x_pos = '0;
      z_pos = '0;
      head = '0;
      fwd_gain_q = longint'(FWD_GAIN_RESET);
      turn_gain_q = longint'(TURN_GAIN_RESET);
      rate_q = longint'(STEP_RATE_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 83;
      for (int i = 0; i < DIRECTED_N; i++) begin
         send_step(directed_steps[i].left, directed_steps[i].right,
                   directed_steps[i].fixed_want, directed_steps[i].want);
      end
      run_random(280);
      settle();

      // every data bit set: top bits beyond the forward gain and step rate registers are dropped
      write_all('1, '1, '1);
      hold_requests = hold_requests + 1;
      run_random(300);
      settle();

      send_idle_pct = 83;
      recv_idle_pct = 18;
      write_all('0, '0, '0);
      run_random(130);
      settle();

      write_all(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      run_random(300);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_all(CSR_DATA_W'($urandom_range(FWD_GAIN_RESET * 2)),
                CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(65535)));
      run_random(300);
      settle();

      write_all(CSR_DATA_W'(FWD_GAIN_RESET), CSR_DATA_W'(TURN_GAIN_RESET),
                CSR_DATA_W'(STEP_RATE_RESET));
      hold_requests = hold_requests + 1;
      run_random(300);
      settle();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
src/ddo_pkg.sv
src/ddo_cordic.sv
src/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
